// ===== hdl/bil_pkg.sv =====
// ----------------------------------------------------------------------------
// bil_pkg
// Shared constants, codes and types for the bounded indexed list.
// ----------------------------------------------------------------------------
package bil_pkg;

   localparam int DEPTH      = 16;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int POS_W      = 5;
   localparam int LIM_W      = 5;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int DATA_W     = 32;
   localparam int OP_W       = 3;
   localparam int STAT_W     = 2;
   localparam int OUT_CNT_W  = 5;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [LIM_W-1:0]      LIMIT_RESET    = LIM_W'(16);
   localparam logic [CSR_ADDR_W-1:0] CSR_LIMIT_ADDR = '0;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_DELETE     = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // broadcast to every cell: open a gap (ins) or close one (del) at pos
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [CNT_W-1:0] pos;
   } cell_cmd_type;

endpackage

// ===== hdl/bil_req_if.sv =====
// ----------------------------------------------------------------------------
// bil_req_if
// Request channel: valid/ready handshake with op, position and value.
// ----------------------------------------------------------------------------
interface bil_req_if;

   logic                                valid;
   logic                                ready;
   logic [bil_pkg::OP_W-1:0]            op;
   logic [bil_pkg::POS_W-1:0]           position;
   logic signed [bil_pkg::DATA_W-1:0]   value;

   modport source (output valid, op, position, value, input ready);
   modport sink   (input valid, op, position, value, output ready);

endinterface

// ===== hdl/bil_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bil_rsp_if
// Response channel: valid/ready handshake with data, status and count.
// ----------------------------------------------------------------------------
interface bil_rsp_if;

   logic                                valid;
   logic                                ready;
   logic signed [bil_pkg::DATA_W-1:0]   data;
   logic [bil_pkg::STAT_W-1:0]          status;
   logic [bil_pkg::OUT_CNT_W-1:0]       count;

   modport source (output valid, data, status, count, input ready);
   modport sink   (input valid, data, status, count, output ready);

endinterface

// ===== hdl/bil_cell.sv =====
// ----------------------------------------------------------------------------
// bil_cell
// One list slot: holds, takes its left or right neighbor, or loads a new value.
// ----------------------------------------------------------------------------
module bil_cell (
   input  logic                                clock,
   input  logic [bil_pkg::IDX_W-1:0]           idx,
   input  bil_pkg::cell_cmd_type               cmd,
   input  logic signed [bil_pkg::DATA_W-1:0]   left_data,
   input  logic signed [bil_pkg::DATA_W-1:0]   right_data,
   input  logic signed [bil_pkg::DATA_W-1:0]   new_value,
   output logic signed [bil_pkg::DATA_W-1:0]   q
);

   logic signed [bil_pkg::DATA_W-1:0] elem_ff;
   logic signed [bil_pkg::DATA_W-1:0] elem_in;
   logic [bil_pkg::CNT_W-1:0]         my_idx;

   assign my_idx = bil_pkg::CNT_W'(idx);

   always_comb begin
      elem_in = elem_ff;
      if (cmd.ins) begin
         if (my_idx > cmd.pos) begin
            elem_in = left_data;
         end else if (my_idx == cmd.pos) begin
            elem_in = new_value;
         end
      end else if (cmd.del && (my_idx >= cmd.pos)) begin
         elem_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign q = elem_ff;

endmodule

// ===== hdl/bil_csr.sv =====
// ----------------------------------------------------------------------------
// bil_csr
// APB-style register port holding the capacity limit.
// ----------------------------------------------------------------------------
module bil_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bil_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bil_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bil_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output logic [bil_pkg::LIM_W-1:0]          capacity_limit
);

   logic [bil_pkg::LIM_W-1:0] limit_ff;
   logic                      wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite
                  && (csr_paddr == bil_pkg::CSR_LIMIT_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= bil_pkg::LIMIT_RESET;
      end else if (wr_en) begin
         limit_ff <= csr_pwdata[bil_pkg::LIM_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == bil_pkg::CSR_LIMIT_ADDR) begin
         csr_prdata = bil_pkg::CSR_DATA_W'(limit_ff);
      end
   end

   assign capacity_limit = limit_ff;

endmodule

// ===== hdl/bounded_indexed_list.sv =====
// Latency: a request transfer produces its response in the next cycle.
// Throughput: one request per cycle while responses are taken; the shift-cell
//    row opens or closes a gap anywhere, with all cells shifting together.
// Reset: element count goes to zero and the capacity limit to 16; the cells
//    themselves are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
// bounded_indexed_list
// Bounded ordered list of signed 32-bit values built as a row of shift cells.
// Push/pop at either end, insert/delete at a position counted from the head.
// ----------------------------------------------------------------------------
module bounded_indexed_list (
   input  logic                               clock,
   input  logic                               reset,
   bil_req_if.sink                            req_port,
   bil_rsp_if.source                          rsp_port,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bil_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bil_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bil_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [bil_pkg::LIM_W-1:0]          capacity_limit;

   // element count and response register
   logic [bil_pkg::CNT_W-1:0]          count_ff;
   logic [bil_pkg::CNT_W-1:0]          count_in;
   logic                               rsp_valid_ff;
   logic signed [bil_pkg::DATA_W-1:0]  rsp_data_ff;
   logic signed [bil_pkg::DATA_W-1:0]  rsp_data_in;
   bil_pkg::status_type                rsp_status_ff;
   bil_pkg::status_type                status_in;
   logic [bil_pkg::OUT_CNT_W-1:0]      rsp_count_ff;

   // decode
   logic                               accept;
   logic [bil_pkg::CMP_W-1:0]          cnt_cmp;
   logic [bil_pkg::CMP_W-1:0]          pos_cmp;
   logic [bil_pkg::CMP_W-1:0]          lim_cmp;
   logic [bil_pkg::CMP_W-1:0]          eff_limit;
   logic                               full;
   logic                               empty;
   logic                               removing;
   bil_pkg::cell_cmd_type              cmd;
   bil_pkg::cell_cmd_type              cell_cmd;

   logic signed [bil_pkg::DATA_W-1:0]  cell_q [bil_pkg::DEPTH];

   bil_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .capacity_limit (capacity_limit)
   );

   // output register frees up as soon as its response is taken
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;

   // limit is min(register, DEPTH); lowering it below the count drops nothing
   assign cnt_cmp   = bil_pkg::CMP_W'(count_ff);
   assign pos_cmp   = bil_pkg::CMP_W'(req_port.position);
   assign lim_cmp   = bil_pkg::CMP_W'(capacity_limit);
   assign eff_limit = (lim_cmp < bil_pkg::CMP_W'(bil_pkg::DEPTH))
                      ? lim_cmp : bil_pkg::CMP_W'(bil_pkg::DEPTH);
   assign full      = cnt_cmp >= eff_limit;
   assign empty     = (count_ff == '0);

   // Full is checked ahead of the position; pops on an empty list are
   // flagged before the position is looked at.
   always_comb begin
      cmd       = '0;
      status_in = bil_pkg::ST_DONE;
      removing  = 1'b0;
      count_in  = count_ff;
      unique case (req_port.op)
         bil_pkg::OP_PUSH_BACK, bil_pkg::OP_PUSH_FRONT, bil_pkg::OP_INSERT: begin
            if (full) begin
               status_in = bil_pkg::ST_FULL;
            end else if ((req_port.op == bil_pkg::OP_INSERT) && (pos_cmp > cnt_cmp)) begin
               status_in = bil_pkg::ST_RANGE;
            end else begin
               cmd.ins  = 1'b1;
               count_in = count_ff + 1'b1;
               unique case (req_port.op)
                  bil_pkg::OP_PUSH_BACK:  cmd.pos = count_ff;
                  bil_pkg::OP_PUSH_FRONT: cmd.pos = '0;
                  default:                cmd.pos = pos_cmp[bil_pkg::CNT_W-1:0];
               endcase
            end
         end
         bil_pkg::OP_POP_BACK, bil_pkg::OP_POP_FRONT, bil_pkg::OP_DELETE: begin
            if (empty) begin
               status_in = bil_pkg::ST_EMPTY;
            end else if ((req_port.op == bil_pkg::OP_DELETE) && (pos_cmp >= cnt_cmp)) begin
               status_in = bil_pkg::ST_RANGE;
            end else begin
               cmd.del  = 1'b1;
               removing = 1'b1;
               count_in = count_ff - 1'b1;
               unique case (req_port.op)
                  bil_pkg::OP_POP_BACK:  cmd.pos = count_ff - 1'b1;
                  bil_pkg::OP_POP_FRONT: cmd.pos = '0;
                  default:               cmd.pos = pos_cmp[bil_pkg::CNT_W-1:0];
               endcase
            end
         end
         default: begin
            // unused op codes: no change, status done
         end
      endcase
   end

   // cells only move on a transfer
   assign cell_cmd = accept ? cmd : '0;

   // removed element is read before the row shifts over it
   assign rsp_data_in = removing ? cell_q[cmd.pos[bil_pkg::IDX_W-1:0]] : '0;

   // the cell row: each cell sees both neighbors
   for (genvar i = 0; i < bil_pkg::DEPTH; i++) begin : g_cell
      logic signed [bil_pkg::DATA_W-1:0] left_d;
      logic signed [bil_pkg::DATA_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = req_port.value;
      end else begin : g_left
         assign left_d = cell_q[i-1];
      end
      if (i == bil_pkg::DEPTH - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_q[i+1];
      end
      bil_cell u_cell (
         .clock      (clock),
         .idx        (bil_pkg::IDX_W'(i)),
         .cmd        (cell_cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .new_value  (req_port.value),
         .q          (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload: no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in[bil_pkg::OUT_CNT_W-1:0];
      end
   end

   assign rsp_port.valid  = rsp_valid_ff;
   assign rsp_port.data   = rsp_data_ff;
   assign rsp_port.status = rsp_status_ff;
   assign rsp_port.count  = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      bil_pkg::CMP_W'(count_ff) <= bil_pkg::CMP_W'(bil_pkg::DEPTH))
      else $error("element count above storage depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (accept && status_in == bil_pkg::ST_FULL) |-> full)
      else $error("full reported below limit");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd.ins) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("count did not grow after insert");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_count_ff == count_ff[bil_pkg::OUT_CNT_W-1:0]))
      else $error("response count differs from element count");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && !removing) |=> (rsp_data_ff == '0))
      else $error("data nonzero without removal");
`endif

endmodule

// ===== tb/tb_bounded_indexed_list.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_indexed_list
// Self-checking bench for the bounded indexed list. A short table of directed
// requests covers the end cases, then randomized traffic runs over several
// capacity limits. A shadow list predicts every response but those written
// into the table; traffic is bursty on the request side and throttled on the response side.
// ----------------------------------------------------------------------------
module tb_bounded_indexed_list;

   timeunit 1ns;
   timeprecision 1ps;

   // op codes the block must ignore (no enum member in the package)
   localparam logic [bil_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [bil_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

   localparam int CYCLE_LIMIT     = 250000;
   localparam int SETTLE_CYCLES   = 4;      // response comes in the cycle after the transfer
   localparam int DRAIN_LIMIT     = 5000;
   localparam int HOLD_CYCLES     = 250;
   localparam int N_PHASES        = 10;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int PRESSURE_ITEMS  = 40;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic signed [bil_pkg::DATA_W-1:0]  data;
      bil_pkg::status_type                status;
      logic [bil_pkg::OUT_CNT_W-1:0]      count;
   } list_rsp_type;

   // directed table: CHECKED rows use the shadow list, TYPED rows carry the
   // response written in, LIMIT rows rewrite capacity_limit (value in val)
   typedef enum logic [1:0] {ROW_CHECKED, ROW_TYPED, ROW_LIMIT} row_kind_type;

   typedef struct packed {
      row_kind_type                       kind;
      logic [bil_pkg::OP_W-1:0]           op;
      logic [bil_pkg::POS_W-1:0]          pos;
      logic signed [bil_pkg::DATA_W-1:0]  val;
      logic signed [bil_pkg::DATA_W-1:0]  data;
      bil_pkg::status_type                status;
      logic [bil_pkg::OUT_CNT_W-1:0]      count;
   } stim_row_type;

   typedef enum logic [1:0] {BIAS_FILL, BIAS_MIXED, BIAS_DRAIN} op_bias_type;
   typedef enum logic [1:0] {
      SINK_STREAM, SINK_LIGHT, SINK_PERIODIC, SINK_HEAVY
   } sink_style_type;

   localparam int N_ROWS = 29;
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      // empty list after reset: every removal is refused
      '{ROW_TYPED,   bil_pkg::OP_POP_BACK,   0,  0,  0, bil_pkg::ST_EMPTY, 0},
      '{ROW_TYPED,   bil_pkg::OP_POP_FRONT,  0,  0,  0, bil_pkg::ST_EMPTY, 0},
      '{ROW_TYPED,   bil_pkg::OP_DELETE,     0,  0,  0, bil_pkg::ST_EMPTY, 0},
      // value extremes at both ends; position ignored on a push
      '{ROW_TYPED,   bil_pkg::OP_PUSH_BACK,  0,  32'sh7FFF_FFFF, 0, bil_pkg::ST_DONE, 1},
      '{ROW_TYPED,   bil_pkg::OP_PUSH_FRONT, 31, 32'sh8000_0000, 0, bil_pkg::ST_DONE, 2},
      // insert past count, then at count (append) and in the middle
      '{ROW_TYPED,   bil_pkg::OP_INSERT,     3,  5,  0, bil_pkg::ST_RANGE, 2},
      '{ROW_CHECKED, bil_pkg::OP_INSERT,     2,  -1, 0, bil_pkg::ST_DONE,  0},
      '{ROW_CHECKED, bil_pkg::OP_INSERT,     1,  0,  0, bil_pkg::ST_DONE,  0},
      // delete at count and far past it
      '{ROW_TYPED,   bil_pkg::OP_DELETE,     4,  0,  0, bil_pkg::ST_RANGE, 4},
      '{ROW_TYPED,   bil_pkg::OP_DELETE,     31, 0,  0, bil_pkg::ST_RANGE, 4},
      // unused op codes leave the list alone
      '{ROW_TYPED,   OP_SPARE_6,             0,  32'sh1234_5678, 0, bil_pkg::ST_DONE, 4},
      '{ROW_TYPED,   OP_SPARE_7,             16, -1, 0, bil_pkg::ST_DONE,  4},
      '{ROW_TYPED,   bil_pkg::OP_POP_FRONT,  0,  0,  32'sh8000_0000, bil_pkg::ST_DONE, 3},
      '{ROW_CHECKED, bil_pkg::OP_POP_BACK,   0,  0,  0, bil_pkg::ST_DONE,  0},
      '{ROW_CHECKED, bil_pkg::OP_DELETE,     1,  0,  0, bil_pkg::ST_DONE,  0},
      '{ROW_CHECKED, bil_pkg::OP_DELETE,     0,  0,  0, bil_pkg::ST_DONE,  0},
      // small limit: fill it, then full wins over a bad position
      '{ROW_LIMIT,   bil_pkg::OP_PUSH_BACK,  0,  2,  0, bil_pkg::ST_DONE,  0},
      '{ROW_CHECKED, bil_pkg::OP_PUSH_BACK,  0,  32'sh5A5A_5A5A, 0, bil_pkg::ST_DONE, 0},
      '{ROW_CHECKED, bil_pkg::OP_INSERT,     0,  32'shA5A5_A5A5, 0, bil_pkg::ST_DONE, 0},
      '{ROW_TYPED,   bil_pkg::OP_PUSH_FRONT, 0,  1,  0, bil_pkg::ST_FULL,  2},
      '{ROW_TYPED,   bil_pkg::OP_INSERT,     31, 1,  0, bil_pkg::ST_FULL,  2},
      // limit lowered under the count keeps the elements
      '{ROW_LIMIT,   bil_pkg::OP_PUSH_BACK,  0,  1,  0, bil_pkg::ST_DONE,  0},
      '{ROW_TYPED,   bil_pkg::OP_PUSH_BACK,  0,  1,  0, bil_pkg::ST_FULL,  2},
      '{ROW_CHECKED, bil_pkg::OP_DELETE,     1,  0,  0, bil_pkg::ST_DONE,  0},
      '{ROW_LIMIT,   bil_pkg::OP_PUSH_BACK,  0,  0,  0, bil_pkg::ST_DONE,  0},
      '{ROW_TYPED,   bil_pkg::OP_INSERT,     0,  1,  0, bil_pkg::ST_FULL,  1},
      '{ROW_CHECKED, bil_pkg::OP_POP_FRONT,  0,  0,  0, bil_pkg::ST_DONE,  0},
      '{ROW_TYPED,   bil_pkg::OP_POP_BACK,   0,  0,  0, bil_pkg::ST_EMPTY, 0},
      '{ROW_LIMIT,   bil_pkg::OP_PUSH_BACK,  0,  16, 0, bil_pkg::ST_DONE,  0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [bil_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [bil_pkg::CSR_DATA_W-1:0]  csr_pwdata;
   logic [bil_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   bil_req_if req_bus ();
   bil_rsp_if rsp_bus ();

   bounded_indexed_list dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus.sink),
      .rsp_port    (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the block: list contents (head at index 0) and the limit
   logic signed [bil_pkg::DATA_W-1:0] shadow_list [$];
   logic [bil_pkg::LIM_W-1:0]         shadow_limit = bil_pkg::LIMIT_RESET;

   // responses owed by the block, oldest first
   list_rsp_type replies_due [$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   bit          gaps_enabled = 1'b1;
   bit          hold_request = 1'b0;
   op_bias_type bias = BIAS_MIXED;

   // -------------------------------------------------------------------------
   // Predictor: apply one request to the shadow list, return its response.
   // Fullness is judged before the position; the effective limit is the
   // smaller of capacity_limit and the storage depth.
   // -------------------------------------------------------------------------
   function automatic list_rsp_type apply_list_op(
         input logic [bil_pkg::OP_W-1:0] op,
         input logic [bil_pkg::POS_W-1:0] pos,
         input logic signed [bil_pkg::DATA_W-1:0] val);
      list_rsp_type r;
      int unsigned  held;
      int unsigned  room;
      bit           full;
      held     = shadow_list.size();
      room     = (shadow_limit < bil_pkg::DEPTH) ? shadow_limit : bil_pkg::DEPTH;
      full     = (held >= room);
      r.data   = '0;
      r.status = bil_pkg::ST_DONE;
      case (op)
         bil_pkg::OP_PUSH_BACK, bil_pkg::OP_PUSH_FRONT, bil_pkg::OP_INSERT: begin
            if (full)
               r.status = bil_pkg::ST_FULL;
            else if (op == bil_pkg::OP_PUSH_BACK)
               shadow_list.insert(held, val);
            else if (op == bil_pkg::OP_PUSH_FRONT)
               shadow_list.insert(0, val);
            else if (pos > held)
               r.status = bil_pkg::ST_RANGE;
            else
               shadow_list.insert(pos, val);
         end
         bil_pkg::OP_POP_BACK, bil_pkg::OP_POP_FRONT, bil_pkg::OP_DELETE: begin
            if (held == 0)
               r.status = bil_pkg::ST_EMPTY;
            else if (op == bil_pkg::OP_POP_BACK) begin
               r.data = shadow_list[held - 1];
               shadow_list.delete(held - 1);
            end else if (op == bil_pkg::OP_POP_FRONT) begin
               r.data = shadow_list[0];
               shadow_list.delete(0);
            end else if (pos >= held)
               r.status = bil_pkg::ST_RANGE;
            else begin
               r.data = shadow_list[pos];
               shadow_list.delete(pos);
            end
         end
         default: ;  // spare codes: no change
      endcase
      r.count = bil_pkg::OUT_CNT_W'(shadow_list.size());
      return r;
   endfunction

   task automatic note_error(input string msg);
      if (error_count < MAX_REPORTS)
         $display("[%0t] %s", $time, msg);
      error_count++;
   endtask

   // Offer one request and hold it until the transfer; predict on transfer.
   // valid stays high across back-to-back requests (one NBA per step).
   task automatic send_item(input logic [bil_pkg::OP_W-1:0] op,
                            input logic [bil_pkg::POS_W-1:0] pos,
                            input logic signed [bil_pkg::DATA_W-1:0] val,
                            input bit typed, input list_rsp_type typed_rsp);
      list_rsp_type predicted;
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.position <= pos;
      req_bus.value    <= val;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_list_op(op, pos, val);
      replies_due.insert(replies_due.size(), typed ? typed_rsp : predicted);
   endtask

   // Sender bursts: random burst length, random gap (occasionally long).
   task automatic sender_pause();
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 4);
         if (gaps_enabled) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // Mostly valid positions with random content; a tenth of the positions
   // and a few op codes are noise. The bias steers the list toward full
   // or empty so both ends get hit.
   task automatic send_random_item();
      logic [bil_pkg::OP_W-1:0]          op;
      logic [bil_pkg::POS_W-1:0]         pos;
      logic signed [bil_pkg::DATA_W-1:0] val;
      int unsigned                       roll;
      int unsigned                       held;
      int unsigned                       push_share;
      held       = shadow_list.size();
      push_share = (bias == BIAS_FILL) ? 60 : (bias == BIAS_DRAIN) ? 22 : 40;
      roll       = $urandom_range(0, 99);
      if (roll < 3)
         op = ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
      else if (roll < 3 + push_share)
         case ($urandom_range(0, 2))
            0:       op = bil_pkg::OP_PUSH_BACK;
            1:       op = bil_pkg::OP_PUSH_FRONT;
            default: op = bil_pkg::OP_INSERT;
         endcase
      else
         case ($urandom_range(0, 2))
            0:       op = bil_pkg::OP_POP_BACK;
            1:       op = bil_pkg::OP_POP_FRONT;
            default: op = bil_pkg::OP_DELETE;
         endcase
      if ($urandom_range(0, 9) == 0)
         pos = bil_pkg::POS_W'($urandom);
      else if (op == bil_pkg::OP_DELETE)
         pos = (held == 0) ? '0 : bil_pkg::POS_W'($urandom_range(0, held - 1));
      else
         pos = bil_pkg::POS_W'($urandom_range(0, held));
      case ($urandom_range(0, 11))
         0:       val = 32'sh7FFF_FFFF;
         1:       val = 32'sh8000_0000;
         2:       val = '0;
         3:       val = -1;
         default: val = $urandom;
      endcase
      sender_pause();
      send_item(op, pos, val, 1'b0, '0);
   endtask

   // Quiesce the request side, let every owed response land, then write
   // capacity_limit with a setup and an access cycle.
   task automatic settle_and_set_limit(input logic [bil_pkg::LIM_W-1:0] lim);
      if (req_bus.valid)
         req_bus.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= bil_pkg::CSR_LIMIT_ADDR;
      csr_pwdata  <= bil_pkg::CSR_DATA_W'(lim);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      shadow_limit = lim;
   endtask

   // -------------------------------------------------------------------------
   // Response checker: every response transfer is matched against the oldest
   // owed response, field by field.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      list_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (replies_due.size() == 0) begin
            note_error($sformatf("response with none owed: data %h status %0d count %0d",
                                 rsp_bus.data, rsp_bus.status, rsp_bus.count));
         end else begin
            want = replies_due[0];
            replies_due.delete(0);
            if (rsp_bus.data !== want.data || rsp_bus.status !== want.status ||
                rsp_bus.count !== want.count)
               note_error($sformatf(
                  "mismatch: data exp %h got %h, status exp %0d got %0d, count exp %0d got %0d",
                  want.data, rsp_bus.data, want.status, rsp_bus.status,
                  want.count, rsp_bus.count));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response ready: segments of random style and length; on request a long
   // hold-off, counted here, so the block backs up and stalls its input.
   // -------------------------------------------------------------------------
   initial begin : rsp_ready_pattern
      int unsigned    seg_left;
      int unsigned    beat;
      sink_style_type style;
      seg_left = 0;
      beat     = 0;
      style    = SINK_STREAM;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (seg_left == 0) begin
               style    = sink_style_type'($urandom_range(0, 3));
               seg_left = $urandom_range(1, 48);
            end
            seg_left--;
            beat++;
            case (style)
               SINK_STREAM:   rsp_bus.ready <= 1'b1;
               SINK_LIGHT:    rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               SINK_PERIODIC: rsp_bus.ready <= (beat % 3 != 0);
               default:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count == CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus: reset, directed table, then randomized phases with a fresh
   // limit each (0, 1, 16 and random ones in between).
   // -------------------------------------------------------------------------
   initial begin : stimulus
      list_rsp_type              typed_rsp;
      logic [bil_pkg::LIM_W-1:0] phase_limit;
      int                        n;
      req_bus.valid    = 1'b0;
      req_bus.op       = bil_pkg::OP_PUSH_BACK;
      req_bus.position = '0;
      req_bus.value    = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = bil_pkg::CSR_LIMIT_ADDR;
      csr_pwdata       = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_LIMIT) begin
            settle_and_set_limit(DIRECTED_ROWS[i].val[bil_pkg::LIM_W-1:0]);
         end else begin
            typed_rsp.data   = DIRECTED_ROWS[i].data;
            typed_rsp.status = DIRECTED_ROWS[i].status;
            typed_rsp.count  = DIRECTED_ROWS[i].count;
            sender_pause();
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].pos, DIRECTED_ROWS[i].val,
                      DIRECTED_ROWS[i].kind == ROW_TYPED, typed_rsp);
         end
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         case (phase)
            1:       phase_limit = '0;
            3:       phase_limit = bil_pkg::LIM_W'(1);
            4, 6, 8: phase_limit = bil_pkg::LIM_W'($urandom_range(2, 15));
            default: phase_limit = bil_pkg::LIM_W'(bil_pkg::DEPTH);
         endcase
         settle_and_set_limit(phase_limit);
         gaps_enabled = (phase != 5);  // one phase runs back to back
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 30 == 0)
               bias = op_bias_type'($urandom_range(0, 2));
            send_random_item();
         end
         if (phase == 2) begin
            // receiver holds off while requests keep coming
            hold_request = 1'b1;
            gaps_enabled = 1'b0;
            repeat (PRESSURE_ITEMS) send_random_item();
            gaps_enabled = 1'b1;
         end
      end

      req_bus.valid <= 1'b0;
      for (n = 0; n < DRAIN_LIMIT && replies_due.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (replies_due.size() != 0)
         note_error($sformatf("%0d responses never arrived", replies_due.size()));

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bil_pkg.sv
hdl/bil_req_if.sv
hdl/bil_rsp_if.sv
hdl/bil_cell.sv
hdl/bil_csr.sv
hdl/bounded_indexed_list.sv
tb/tb_bounded_indexed_list.sv
